// ===== src/sasu_pkg.sv =====
// Package for the spiral arm angle sequencer: field widths, register indexes,
// order mode codes and the structs passed between the pipeline stages.
// No dependencies.
package sasu_pkg;

	// Widths fixed by the register and field formats.
	localparam int CNT_W        = 9;              // arm and echo counts
	localparam int POS_W        = 2 * CNT_W;      // position and total
	localparam int ORD_W        = POS_W + 1;      // order value before masking
	localparam int STEP_W       = 32;             // angle step register
	localparam int CFG_DATA_W   = 32;             // widest register
	localparam int CFG_INDEX_W  = 3;
	localparam int IDX_OUT_W    = 8;              // arm_index, echo_index
	localparam int ORDER_OUT_W  = 16;
	localparam int ANGLE_OUT_W  = 32;

	// Defaults of the top-level parameters.
	localparam int DEF_MAX_ARMS   = 256;
	localparam int DEF_MAX_ECHOES = 256;
	localparam int DEF_ANGLE_BITS = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_NUM_ARMS        = 3'd0,
		REG_NUM_ECHOES      = 3'd1,
		REG_INCOHERENT_MODE = 3'd2,
		REG_ORDER_MODE      = 3'd3,
		REG_ANGLE_STEP      = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		ORD_LINEAR  = 2'd0,
		ORD_SKIP    = 2'd1,
		ORD_TWO_WAY = 2'd2,
		ORD_MIXED   = 2'd3
	} order_mode_t;

	// Configuration as the datapath sees it, counts already clamped.
	typedef struct packed {
		logic [CNT_W-1:0]  arms;
		logic [CNT_W-1:0]  echoes;
		logic              incoherent;
		order_mode_t       mode;
		logic [STEP_W-1:0] step;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] arm;
		logic [CNT_W-1:0] echo;
		logic             last;
	} walk_t;

	typedef struct packed {
		walk_t            walk;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] total;
	} pos_t;

	typedef struct packed {
		walk_t            walk;
		logic [ORD_W-1:0] ord;
	} ord_t;

endpackage

// ===== src/sasu_if.sv =====
// Handshake interfaces of the spiral arm angle sequencer: request channel and
// result channel, each with valid, ready and payload. Uses sasu_pkg widths.
interface sasu_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface sasu_res_if;
	logic                                 valid;
	logic                                 ready;
	logic [sasu_pkg::IDX_OUT_W-1:0]       arm_index;
	logic [sasu_pkg::IDX_OUT_W-1:0]       echo_index;
	logic [sasu_pkg::ORDER_OUT_W-1:0]     order_value;
	logic [sasu_pkg::ANGLE_OUT_W-1:0]     angle;
	logic                                 last;

	modport source (output valid, output arm_index, output echo_index, output order_value,
		output angle, output last, input ready);
	modport sink (input valid, input arm_index, input echo_index, input order_value,
		input angle, input last, output ready);
endinterface

// ===== src/sasu_walk.sv =====
// Arm/echo walk counters and the first pipeline stage of the sequencer.
// Depends on sasu_pkg.
module sasu_walk #(
	parameter int MAX_ARMS   = sasu_pkg::DEF_MAX_ARMS,
	parameter int MAX_ECHOES = sasu_pkg::DEF_MAX_ECHOES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sasu_pkg::cfg_t  cfg,
	input  logic            up_valid,
	input  logic            restart,
	output logic            up_ready,
	output logic            v_s1,
	output sasu_pkg::walk_t walk_s1,
	input  logic            down_ready
);

	// Counter widths: a count never exceeds what the 9-bit registers can hold.
	localparam int ARM_CW  = (MAX_ARMS > 512) ? sasu_pkg::CNT_W :
		((MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1);
	localparam int ECHO_CW = (MAX_ECHOES > 512) ? sasu_pkg::CNT_W :
		((MAX_ECHOES > 1) ? $clog2(MAX_ECHOES) : 1);
	localparam int CW1     = sasu_pkg::CNT_W + 1;

	logic [ARM_CW-1:0]  arm_q, arm_cur, arm_nxt;
	logic [ECHO_CW-1:0] echo_q, echo_cur, echo_nxt;
	logic               wrap;
	logic               take;
	logic               last;

	assign up_ready = !v_s1 || down_ready;
	assign take     = up_valid && up_ready;

	// A restart, or counters left outside a set that has since shrunk, starts
	// the walk over at arm 0, echo 0.
	always_comb begin
		wrap     = restart || (sasu_pkg::CNT_W'(arm_q) >= cfg.arms) ||
			(sasu_pkg::CNT_W'(echo_q) >= cfg.echoes);
		arm_cur  = wrap ? '0 : arm_q;
		echo_cur = wrap ? '0 : echo_q;
		last     = (sasu_pkg::CNT_W'(arm_cur) == cfg.arms - sasu_pkg::CNT_W'(1)) &&
			(sasu_pkg::CNT_W'(echo_cur) == cfg.echoes - sasu_pkg::CNT_W'(1));
		if (CW1'(echo_cur) + CW1'(1) < CW1'(cfg.echoes)) begin
			echo_nxt = echo_cur + ECHO_CW'(1);
			arm_nxt  = arm_cur;
		end else begin
			echo_nxt = '0;
			arm_nxt  = (CW1'(arm_cur) + CW1'(1) < CW1'(cfg.arms)) ?
				arm_cur + ARM_CW'(1) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_q  <= '0;
			echo_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (take) begin
				arm_q  <= arm_nxt;
				echo_q <= echo_nxt;
			end
			if (up_ready) begin
				v_s1 <= up_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			walk_s1.arm  <= sasu_pkg::CNT_W'(arm_cur);
			walk_s1.echo <= sasu_pkg::CNT_W'(echo_cur);
			walk_s1.last <= last;
		end
	end

	a_restart_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(take && restart) |=> (v_s1 && walk_s1.arm == '0 && walk_s1.echo == '0))
		else $error("restart did not start the walk at arm 0, echo 0");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !down_ready) |=> (v_s1 && $stable(walk_s1)))
		else $error("stage 1 item lost or changed while stalled");

endmodule

// ===== src/sasu_order.sv =====
// Position, total and order value stages of the sequencer: stage 2 forms the
// position and total, stage 3 maps the position to an order value. Uses sasu_pkg.
module sasu_order (
	input  logic            clk,
	input  logic            arst_n,
	input  sasu_pkg::cfg_t  cfg,
	input  logic            v_s1,
	input  sasu_pkg::walk_t walk_s1,
	output logic            s1_ready,
	output logic            v_s3,
	output sasu_pkg::ord_t  ord_s3,
	input  logic            s3_ready
);

	logic                        v_s2;
	sasu_pkg::pos_t              pos_s2;
	logic                        s2_ready;
	logic [sasu_pkg::POS_W-1:0]  pos, total;
	logic [sasu_pkg::ORD_W-1:0]  p, t, h, e, ord;

	assign s1_ready = !v_s2 || s2_ready;
	assign s2_ready = !v_s3 || s3_ready;

	// Incoherent mode gives every echo its own position.
	always_comb begin
		if (cfg.incoherent) begin
			pos   = sasu_pkg::POS_W'(walk_s1.arm) +
				sasu_pkg::POS_W'(walk_s1.echo) * sasu_pkg::POS_W'(cfg.arms);
			total = sasu_pkg::POS_W'(cfg.arms) * sasu_pkg::POS_W'(cfg.echoes);
		end else begin
			pos   = sasu_pkg::POS_W'(walk_s1.arm);
			total = sasu_pkg::POS_W'(cfg.arms);
		end
	end

	// Closed forms of the ordering schemes; h is half the total rounded down,
	// e is half rounded up.
	always_comb begin
		p = sasu_pkg::ORD_W'(pos_s2.pos);
		t = sasu_pkg::ORD_W'(pos_s2.total);
		h = t >> 1;
		e = (t + sasu_pkg::ORD_W'(1)) >> 1;
		case (cfg.mode)
			sasu_pkg::ORD_LINEAR: begin
				ord = p;
			end
			sasu_pkg::ORD_SKIP: begin
				ord = (p < e) ? (p << 1) : sasu_pkg::ORD_W'(1) + ((p - e) << 1);
			end
			sasu_pkg::ORD_TWO_WAY: begin
				ord = p[0] ? t - sasu_pkg::ORD_W'(1) - (p >> 1) : (p >> 1);
			end
			sasu_pkg::ORD_MIXED: begin
				if (p < h) begin
					ord = p[0] ? t - sasu_pkg::ORD_W'(2) - (p << 1) :
						sasu_pkg::ORD_W'(1) + (p << 1);
				end else begin
					ord = p[0] ? ((p - h) << 1) :
						t - sasu_pkg::ORD_W'(1) - ((p - h) << 1);
				end
			end
			default: begin
				ord = p;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s2 <= v_s1;
			end
			if (s2_ready) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && s1_ready) begin
			pos_s2.walk  <= walk_s1;
			pos_s2.pos   <= pos;
			pos_s2.total <= total;
		end
		if (v_s2 && s2_ready) begin
			ord_s3.walk <= pos_s2.walk;
			ord_s3.ord  <= ord;
		end
	end

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !s2_ready) |=> (v_s2 && $stable(pos_s2)))
		else $error("stage 2 item lost or changed while stalled");

endmodule

// ===== src/sasu_angle.sv =====
// Angle multiply and output register of the sequencer: angle step times order
// value, wrapped to a full turn. Drives the result interface; uses sasu_pkg.
module sasu_angle #(
	parameter int ANGLE_BITS = sasu_pkg::DEF_ANGLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sasu_pkg::STEP_W-1:0]   step,
	input  logic                          v_s3,
	input  sasu_pkg::ord_t                ord_s3,
	output logic                          s3_ready,
	sasu_res_if.source                    res
);

	localparam int PROD_W = sasu_pkg::STEP_W + sasu_pkg::ORD_W;

	logic                                 v_s4;
	logic [PROD_W-1:0]                    prod;
	logic [sasu_pkg::ANGLE_OUT_W-1:0]     angle;

	assign s3_ready  = !v_s4 || res.ready;
	assign res.valid = v_s4;

	always_comb begin
		prod  = PROD_W'(step) * PROD_W'(ord_s3.ord);
		angle = sasu_pkg::ANGLE_OUT_W'(prod[ANGLE_BITS-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (s3_ready) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && s3_ready) begin
			res.arm_index   <= sasu_pkg::IDX_OUT_W'(ord_s3.walk.arm);
			res.echo_index  <= sasu_pkg::IDX_OUT_W'(ord_s3.walk.echo);
			res.order_value <= sasu_pkg::ORDER_OUT_W'(ord_s3.ord);
			res.angle       <= angle;
			res.last        <= ord_s3.walk.last;
		end
	end

	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && s3_ready) |=> v_s4)
		else $error("item taken from stage 3 did not reach the output register");

endmodule

// ===== src/spiral_arm_angle_sequencer_unit.sv =====
// Top level of the spiral arm angle sequencer: configuration registers and the
// four-stage walk, order and angle pipeline. Depends on sasu_pkg, sasu_if.sv,
// sasu_walk, sasu_order and sasu_angle.
//
// Usage: every item on the req channel asks for the angle of the next arm/echo
// pair; req.restart set on an item starts the walk over at arm 0, echo 0
// before that item is served. Each item yields exactly one item on the res
// channel, carrying the arm and echo numbers, the order value, the rotation
// angle (2^ANGLE_BITS is a full turn) and a flag on the final pair of the set.
// An accepted item passes through the walk, position, order and angle multiply
// stage registers, in that order, before it shows on res.
// Throughput is one item per cycle; the stages hand over with bubble-collapsing
// valid bits, so req.ready stays high while any stage has room.
// When the receiver stalls, results wait in the pipeline registers; up to four
// items are held before req.ready drops.
// Reset clears all stage valid bits and the walk counters and loads the
// registers with one arm, one echo, coherent mode, linear order and a zero step.
// The user must write registers through cfg_we/cfg_index/cfg_data only while no
// item is in flight; the block does not check it. Unknown indexes are ignored.
module spiral_arm_angle_sequencer_unit #(
	parameter int MAX_ARMS   = sasu_pkg::DEF_MAX_ARMS,
	parameter int MAX_ECHOES = sasu_pkg::DEF_MAX_ECHOES,
	parameter int ANGLE_BITS = sasu_pkg::DEF_ANGLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sasu_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sasu_pkg::CFG_DATA_W-1:0]   cfg_data,
	sasu_req_if.sink                          req,
	sasu_res_if.source                        res
);

	logic [sasu_pkg::CNT_W-1:0]   num_arms_q;
	logic [sasu_pkg::CNT_W-1:0]   num_echoes_q;
	logic                         incoherent_q;
	sasu_pkg::order_mode_t        order_mode_q;
	logic [sasu_pkg::STEP_W-1:0]  angle_step_q;

	sasu_pkg::cfg_t   cfg;
	logic             v_s1, s1_ready;
	sasu_pkg::walk_t  walk_s1;
	logic             v_s3, s3_ready;
	sasu_pkg::ord_t   ord_s3;

	// Register writes. A count of zero is used as one, and counts above the
	// parameter limits saturate at the limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_arms_q   <= sasu_pkg::CNT_W'(1);
			num_echoes_q <= sasu_pkg::CNT_W'(1);
			incoherent_q <= 1'b0;
			order_mode_q <= sasu_pkg::ORD_LINEAR;
			angle_step_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sasu_pkg::REG_NUM_ARMS:        num_arms_q   <= cfg_data[sasu_pkg::CNT_W-1:0];
				sasu_pkg::REG_NUM_ECHOES:      num_echoes_q <= cfg_data[sasu_pkg::CNT_W-1:0];
				sasu_pkg::REG_INCOHERENT_MODE: incoherent_q <= cfg_data[0];
				sasu_pkg::REG_ORDER_MODE:
					order_mode_q <= sasu_pkg::order_mode_t'(cfg_data[1:0]);
				sasu_pkg::REG_ANGLE_STEP:
					angle_step_q <= cfg_data[sasu_pkg::STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (num_arms_q == '0) begin
			cfg.arms = sasu_pkg::CNT_W'(1);
		end else if (int'(num_arms_q) > MAX_ARMS) begin
			cfg.arms = sasu_pkg::CNT_W'(MAX_ARMS);
		end else begin
			cfg.arms = num_arms_q;
		end
		if (num_echoes_q == '0) begin
			cfg.echoes = sasu_pkg::CNT_W'(1);
		end else if (int'(num_echoes_q) > MAX_ECHOES) begin
			cfg.echoes = sasu_pkg::CNT_W'(MAX_ECHOES);
		end else begin
			cfg.echoes = num_echoes_q;
		end
		cfg.incoherent = incoherent_q;
		cfg.mode       = order_mode_q;
		cfg.step       = angle_step_q;
	end

	sasu_walk #(
		.MAX_ARMS   (MAX_ARMS),
		.MAX_ECHOES (MAX_ECHOES)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.up_valid   (req.valid),
		.restart    (req.restart),
		.up_ready   (req.ready),
		.v_s1       (v_s1),
		.walk_s1    (walk_s1),
		.down_ready (s1_ready)
	);

	sasu_order u_order (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.v_s1     (v_s1),
		.walk_s1  (walk_s1),
		.s1_ready (s1_ready),
		.v_s3     (v_s3),
		.ord_s3   (ord_s3),
		.s3_ready (s3_ready)
	);

	sasu_angle #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_angle (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (cfg.step),
		.v_s3     (v_s3),
		.ord_s3   (ord_s3),
		.s3_ready (s3_ready),
		.res      (res)
	);

endmodule

// ===== tb/tb_spiral_arm_angle_sequencer_unit.sv =====
// Self-checking testbench for spiral_arm_angle_sequencer_unit: a directed table, then random
// register settings and random request streams checked against a behavioral predictor.
// Depends on sasu_pkg and the sasu_req_if / sasu_res_if interfaces.
module tb_spiral_arm_angle_sequencer_unit;

	// Four pipeline stages between an accepted request and its result.
	localparam int PIPE_LATENCY  = 4;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int REPORT_LIMIT  = 10;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int RUN_LIMIT     = 1000000;
	// Register indexes past the last defined one must be ignored by the block.
	localparam int SPARE_INDEX_LO = int'(sasu_pkg::REG_ANGLE_STEP) + 1;
	localparam int SPARE_INDEX_HI = (1 << sasu_pkg::CFG_INDEX_W) - 1;
	localparam logic [sasu_pkg::CFG_DATA_W-1:0] COUNT_MASK = (1 << sasu_pkg::CNT_W) - 1;

	// One result item as it appears on the res channel.
	typedef struct packed {
		logic [sasu_pkg::IDX_OUT_W-1:0]   arm_index;
		logic [sasu_pkg::IDX_OUT_W-1:0]   echo_index;
		logic [sasu_pkg::ORDER_OUT_W-1:0] order_value;
		logic [sasu_pkg::ANGLE_OUT_W-1:0] angle;
		logic                             last;
	} angle_item_t;

	// A hand-written answer travels with each request; known = 0 means "use the predictor".
	typedef struct packed {
		logic        known;
		angle_item_t want;
	} typed_answer_t;

	// One row of the directed table. When set_cfg is high, all five registers are rewritten
	// (after the block has gone idle) before the request of that row is sent.
	typedef struct packed {
		logic                            set_cfg;
		logic [sasu_pkg::CFG_DATA_W-1:0] arms;
		logic [sasu_pkg::CFG_DATA_W-1:0] echoes;
		logic                            incoherent;
		sasu_pkg::order_mode_t           mode;
		logic [sasu_pkg::STEP_W-1:0]     step;
		logic                            restart;
		logic                            known;
		angle_item_t                     want;
	} plan_row_t;

	localparam int DIRECTED_ROWS = 24;

	// Directed table. Expected results are typed in where they are obvious: the single pair
	// after reset, zero counts read as one, a saturated arm count with the largest step, a
	// walk that restarts mid-set, counters left past a shrunken set, and a tiny mixed-order
	// set that wraps. The skip, two-way and mixed rows in the middle rely on the predictor.
	plan_row_t directed_plan [DIRECTED_ROWS] = '{
		// Defaults after reset: one arm, one echo, so the first pair is also the last.
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b1,
			'{8'd0, 8'd0, 16'd0, 32'd0, 1'b1}},
		// Zero arms and zero echoes behave as one of each.
		'{1'b1, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 32'hFFFF_FFFF, 1'b0, 1'b1,
			'{8'd0, 8'd0, 16'd0, 32'd0, 1'b1}},
		// All ones in the arm count saturates at the maximum; the step wraps the angle.
		'{1'b1, 32'hFFFF_FFFF, 1, 1'b0, sasu_pkg::ORD_LINEAR, 32'hFFFF_FFFF, 1'b1, 1'b1,
			'{8'd0, 8'd0, 16'd0, 32'd0, 1'b0}},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b1,
			'{8'd1, 8'd0, 16'd1, 32'hFFFF_FFFF, 1'b0}},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b1,
			'{8'd2, 8'd0, 16'd2, 32'hFFFF_FFFE, 1'b0}},
		// Restart in the middle of the set.
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b1, 1'b1,
			'{8'd0, 8'd0, 16'd0, 32'd0, 1'b0}},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b1,
			'{8'd1, 8'd0, 16'd1, 32'hFFFF_FFFF, 1'b0}},
		// The arm counter now sits past a one-arm set, so the walk starts over by itself.
		'{1'b1, 1, 32'h0000_01FF, 1'b1, sasu_pkg::ORD_LINEAR, 1, 1'b0, 1'b1,
			'{8'd0, 8'd0, 16'd0, 32'd0, 1'b0}},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b1,
			'{8'd0, 8'd1, 16'd1, 32'd1, 1'b0}},
		// Skip order, incoherent.
		'{1'b1, 5, 3, 1'b1, sasu_pkg::ORD_SKIP, 32'h1000_0001, 1'b1, 1'b0, '0},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b0, '0},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b0, '0},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b0, '0},
		// Two-way order, coherent, half-turn step.
		'{1'b1, 6, 2, 1'b0, sasu_pkg::ORD_TWO_WAY, 32'h8000_0000, 1'b1, 1'b0, '0},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b0, '0},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b0, '0},
		// Mixed order, incoherent, no restart after the size change.
		'{1'b1, 7, 3, 1'b1, sasu_pkg::ORD_MIXED, 32'h9E37_79B9, 1'b0, 1'b0, '0},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b0, '0},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b0, '0},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b0, '0},
		// Mixed order over three arms: order values 1, 0, 0, then the walk wraps.
		'{1'b1, 3, 1, 1'b0, sasu_pkg::ORD_MIXED, 0, 1'b1, 1'b1,
			'{8'd0, 8'd0, 16'd1, 32'd0, 1'b0}},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b1,
			'{8'd1, 8'd0, 16'd0, 32'd0, 1'b0}},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b1,
			'{8'd2, 8'd0, 16'd0, 32'd0, 1'b1}},
		'{1'b0, 0, 0, 1'b0, sasu_pkg::ORD_LINEAR, 0, 1'b0, 1'b1,
			'{8'd0, 8'd0, 16'd1, 32'd0, 1'b0}}
	};

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [sasu_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [sasu_pkg::CFG_DATA_W-1:0]  cfg_data;

	sasu_req_if req_ch();
	sasu_res_if res_ch();

	spiral_arm_angle_sequencer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	// Register copy and walk position kept by the predictor.
	logic [sasu_pkg::CNT_W-1:0]  set_arms;
	logic [sasu_pkg::CNT_W-1:0]  set_echoes;
	logic                        set_incoherent;
	sasu_pkg::order_mode_t       set_mode;
	logic [sasu_pkg::STEP_W-1:0] set_step;
	int unsigned                 walk_arm;
	int unsigned                 walk_echo;

	angle_item_t   pending_angles [$];
	typed_answer_t typed_answers [$];
	int            items_issued;
	int            items_returned;
	int            failures;
	// When set, the request side sends back to back for the whole phase.
	bit            sender_steady;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Gap lengths for both sides: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Order value of position p within a set of t positions.
	function automatic int unsigned order_for_position(int unsigned p, int unsigned t,
			sasu_pkg::order_mode_t m);
		int unsigned h;
		int unsigned e;
		h = t / 2;
		e = (t + 1) / 2;
		case (m)
			sasu_pkg::ORD_SKIP: begin
				return (p < e) ? 2 * p : 1 + 2 * (p - e);
			end
			sasu_pkg::ORD_TWO_WAY: begin
				return p[0] ? t - 1 - p / 2 : p / 2;
			end
			sasu_pkg::ORD_MIXED: begin
				if (p < h)
					return p[0] ? t - 2 - 2 * p : 1 + 2 * p;
				return p[0] ? 2 * (p - h) : t - 1 - 2 * (p - h);
			end
			default: begin
				return p;
			end
		endcase
	endfunction

	// Computes the result for one request and advances the walk, arm-major with the echo
	// as the inner index. Counts of zero read as one; counts above the maximum saturate.
	function automatic angle_item_t next_spiral_angle(logic restart_bit);
		int unsigned arms;
		int unsigned echoes;
		int unsigned pos;
		int unsigned total;
		int unsigned ord;
		logic [63:0] product;
		angle_item_t item;
		arms = (set_arms == 0) ? 1 :
			(set_arms > sasu_pkg::DEF_MAX_ARMS ? sasu_pkg::DEF_MAX_ARMS : set_arms);
		echoes = (set_echoes == 0) ? 1 :
			(set_echoes > sasu_pkg::DEF_MAX_ECHOES ? sasu_pkg::DEF_MAX_ECHOES : set_echoes);
		// A restart, or a walk left outside a set that has shrunk, begins at the first pair.
		if (restart_bit || walk_arm >= arms || walk_echo >= echoes) begin
			walk_arm = 0;
			walk_echo = 0;
		end
		if (set_incoherent) begin
			pos = walk_arm + walk_echo * arms;
			total = arms * echoes;
		end else begin
			pos = walk_arm;
			total = arms;
		end
		ord = order_for_position(pos, total, set_mode);
		product = 64'(set_step) * 64'(ord);
		item.arm_index = walk_arm[sasu_pkg::IDX_OUT_W-1:0];
		item.echo_index = walk_echo[sasu_pkg::IDX_OUT_W-1:0];
		item.order_value = ord[sasu_pkg::ORDER_OUT_W-1:0];
		item.angle = product[sasu_pkg::ANGLE_OUT_W-1:0];
		item.last = (walk_arm == arms - 1) && (walk_echo == echoes - 1);
		if (walk_echo + 1 < echoes) begin
			walk_echo++;
		end else begin
			walk_echo = 0;
			walk_arm = (walk_arm + 1 < arms) ? walk_arm + 1 : 0;
		end
		return item;
	endfunction

	function automatic string describe(angle_item_t a);
		return $sformatf("arm %0d echo %0d order %0d angle %h last %b",
			a.arm_index, a.echo_index, a.order_value, a.angle, a.last);
	endfunction

	// Only the first few failures are printed in full; the rest are counted.
	function automatic void report_failure(string what);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("ERROR at %0t: %s", $time, what);
	endfunction

	// Everything is sampled at the rising edge, before the block's own updates land, so the
	// predictor sees exactly the register writes, requests and results of that edge.
	always @(posedge clk) begin : observe
		angle_item_t got;
		angle_item_t want;
		typed_answer_t tag;
		if (!arst_n) begin
			set_arms <= sasu_pkg::CNT_W'(1);
			set_echoes <= sasu_pkg::CNT_W'(1);
			set_incoherent <= 1'b0;
			set_mode <= sasu_pkg::ORD_LINEAR;
			set_step <= '0;
			walk_arm = 0;
			walk_echo = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sasu_pkg::REG_NUM_ARMS:
						set_arms <= cfg_data[sasu_pkg::CNT_W-1:0];
					sasu_pkg::REG_NUM_ECHOES:
						set_echoes <= cfg_data[sasu_pkg::CNT_W-1:0];
					sasu_pkg::REG_INCOHERENT_MODE:
						set_incoherent <= cfg_data[0];
					sasu_pkg::REG_ORDER_MODE:
						set_mode <= sasu_pkg::order_mode_t'(cfg_data[1:0]);
					sasu_pkg::REG_ANGLE_STEP:
						set_step <= cfg_data[sasu_pkg::STEP_W-1:0];
					default: ;
				endcase
			end
			if (req_ch.valid && req_ch.ready) begin
				want = next_spiral_angle(req_ch.restart);
				if (typed_answers.size() != 0) begin
					tag = typed_answers.pop_front();
					if (tag.known)
						want = tag.want;
				end
				pending_angles.push_back(want);
			end
			if (res_ch.valid && res_ch.ready) begin
				items_returned++;
				got = '{res_ch.arm_index, res_ch.echo_index, res_ch.order_value,
					res_ch.angle, res_ch.last};
				if (pending_angles.size() == 0) begin
					report_failure({"result with nothing expected: ", describe(got)});
				end else begin
					want = pending_angles.pop_front();
					if (got.arm_index !== want.arm_index || got.echo_index !== want.echo_index
							|| got.order_value !== want.order_value
							|| got.angle !== want.angle || got.last !== want.last)
						report_failure({"expected ", describe(want), ", got ", describe(got)});
				end
			end
		end
	end

	// Result side: ready is held high for runs of random length, sometimes long stretches
	// with no stall at all, and dropped for random gaps in between.
	initial begin : receiver
		int run;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			res_ch.ready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
			repeat (run) @(posedge clk);
			run = pick_gap();
			if (run > 0) begin
				res_ch.ready <= 1'b0;
				repeat (run) @(posedge clk);
			end
		end
	end

	// Offers one request item and waits for it to be taken. Valid stays high into the
	// next item when no gap is drawn, so it is never lowered and raised in one step.
	task automatic send_item(logic restart_bit, logic known, angle_item_t want);
		int gap;
		typed_answers.push_back('{known, want});
		req_ch.valid <= 1'b1;
		req_ch.restart <= restart_bit;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		items_issued++;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			req_ch.restart <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every accepted item has come back, then lets the
	// pipeline settle.
	task automatic wait_idle();
		int waited;
		req_ch.valid <= 1'b0;
		waited = 0;
		while (items_returned < items_issued && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(logic [sasu_pkg::CFG_INDEX_W-1:0] idx,
			logic [sasu_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Rewrites the registers selected in which (bit i for register index i) while the block
	// is idle. Bits above each register's width carry random junk that must be dropped, and
	// every setting starts with a write to an unused index.
	task automatic write_settings(logic [4:0] which, logic [sasu_pkg::CFG_DATA_W-1:0] arms,
			logic [sasu_pkg::CFG_DATA_W-1:0] echoes, logic incoherent,
			sasu_pkg::order_mode_t mode, logic [sasu_pkg::STEP_W-1:0] step);
		wait_idle();
		write_reg(sasu_pkg::CFG_INDEX_W'($urandom_range(SPARE_INDEX_HI, SPARE_INDEX_LO)),
			$urandom);
		if (which[sasu_pkg::REG_NUM_ARMS])
			write_reg(sasu_pkg::REG_NUM_ARMS,
				($urandom << sasu_pkg::CNT_W) | (arms & COUNT_MASK));
		if (which[sasu_pkg::REG_NUM_ECHOES])
			write_reg(sasu_pkg::REG_NUM_ECHOES,
				($urandom << sasu_pkg::CNT_W) | (echoes & COUNT_MASK));
		if (which[sasu_pkg::REG_INCOHERENT_MODE])
			write_reg(sasu_pkg::REG_INCOHERENT_MODE,
				($urandom << 1) | sasu_pkg::CFG_DATA_W'(incoherent));
		if (which[sasu_pkg::REG_ORDER_MODE])
			write_reg(sasu_pkg::REG_ORDER_MODE,
				($urandom << 2) | sasu_pkg::CFG_DATA_W'(mode));
		if (which[sasu_pkg::REG_ANGLE_STEP])
			write_reg(sasu_pkg::REG_ANGLE_STEP, step);
		cfg_we <= 1'b0;
	endtask

	// Random count: mostly small so that whole sets complete and the last flag shows up,
	// sometimes zero, exactly the maximum, or past the maximum.
	function automatic logic [sasu_pkg::CFG_DATA_W-1:0] pick_count(int small_max);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 0;
		if (r < 10)
			return $urandom_range(sasu_pkg::DEF_MAX_ARMS + 1, int'(COUNT_MASK));
		if (r < 13)
			return sasu_pkg::DEF_MAX_ARMS;
		return $urandom_range(1, small_max);
	endfunction

	initial begin : stimulus
		logic [sasu_pkg::CFG_DATA_W-1:0] arms;
		logic [sasu_pkg::CFG_DATA_W-1:0] echoes;
		logic [sasu_pkg::STEP_W-1:0]     step;
		logic [4:0]                      which;
		logic                            incoherent;
		logic                            restart_bit;
		bit                              deep;
		int                              phase_items;
		int                              r;
		int                              waited;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.restart <= 1'b0;
		sender_steady = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].set_cfg)
				write_settings('1, directed_plan[i].arms, directed_plan[i].echoes,
					directed_plan[i].incoherent, directed_plan[i].mode, directed_plan[i].step);
			send_item(directed_plan[i].restart, directed_plan[i].known, directed_plan[i].want);
		end

		// Random phases: a fresh setting, then a stream of requests that mostly walks
		// forward, with an occasional restart. A few deep phases use the full 256 by 256
		// incoherent set so that positions and order values reach their upper range.
		while (items_issued < DIRECTED_ROWS + RANDOM_ITEMS) begin
			deep = ($urandom_range(0, 29) == 0);
			if (deep) begin
				arms = sasu_pkg::DEF_MAX_ARMS;
				echoes = sasu_pkg::DEF_MAX_ECHOES;
				incoherent = 1'b1;
				which = '1;
			end else begin
				arms = pick_count(8);
				echoes = pick_count(4);
				incoherent = 1'($urandom_range(0, 1));
				foreach (which[b])
					which[b] = ($urandom_range(0, 6) != 0);
			end
			r = $urandom_range(0, 99);
			step = (r < 10) ? '0 : (r < 20) ? '1 : sasu_pkg::STEP_W'($urandom);
			sender_steady = ($urandom_range(0, 3) == 0);
			write_settings(which, arms, echoes, incoherent,
				sasu_pkg::order_mode_t'($urandom_range(0, 3)), step);
			phase_items = deep ? $urandom_range(130, 200) : $urandom_range(10, 60);
			for (int n = 0; n < phase_items; n++) begin
				if (n == 0)
					restart_bit = 1'($urandom_range(0, 1));
				else
					restart_bit = ($urandom_range(0, 15) == 0);
				send_item(restart_bit, 1'b0, '0);
			end
		end

		req_ch.valid <= 1'b0;
		waited = 0;
		while (items_returned < items_issued && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4 * PIPE_LATENCY) @(posedge clk);
		if (pending_angles.size() != 0)
			report_failure($sformatf("%0d expected items never arrived",
				pending_angles.size()));
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin : watchdog
		#RUN_LIMIT;
		$display("FAILURE");
		$finish;
	end

endmodule
